/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/cmr_pkg.sv */
`timescale 1ns / 1ps

package cmr_pkg;

    // Default sizing
    localparam int NUM_SOURCES_DEF = 16;
    localparam int MAX_CHUNKS_DEF  = 10;

    // Field widths
    localparam int ID_W      = 11;
    localparam int CNT_W     = 4;
    localparam int DATA_W    = 64;
    localparam int NODE_W    = 4;
    localparam int PRI_W     = 2;
    localparam int TALLY_W   = 4;
    localparam int SLEN_W    = 3;
    localparam int SBYTES_W  = 56;
    localparam int SLOT_W    = SLEN_W + SBYTES_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARSE_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_RDY = 2'd2;

    // Protocol constants
    localparam logic [NODE_W-1:0] BCAST_ADDR = 4'hF;
    localparam logic [7:0]        DIGIT_ZERO = 8'h30;
    localparam logic [CNT_W-1:0]  MAX_BYTES  = 4'd8;

    // Zero every byte at or above position n
    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] v,
                                                     input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (CNT_W'(i) < n) begin
                m[i*8 +: 8] = v[i*8 +: 8];
            end
        end
        return m;
    endfunction

endpackage

/* src/can_message_reassembler.sv */
`timescale 1ns / 1ps
// CAN message reassembler.
// Input channel: one received frame per item (identifier, byte count, data), taken
// when i_in_valid is high and o_in_stall is low. o_in_stall is high while an item
// is being worked on; the block handles one frame at a time.
// Output channel: one piece per item on o_out_valid / i_out_stall. A piece sits in
// an output register; a stalled piece holds, and the sequencer waits on it.
// Per frame: a dropped or continuation frame passes through S_CHECK back to idle.
// A lone frame goes from S_CHECK to S_LAST, which loads its piece. A final frame with T
// stored chunks reads slots 0 to T-1 before S_LAST loads its own piece (T is at most
// ten): each slot takes S_READ for the slot RAM's registered read and S_SLOT
// to load the output register, all addresses coming from one shared adder.
// Slot data lives in a single-port-write, registered-read RAM; per-slot valid bits,
// per-source tallies and active flags are flops.
// Reset (synchronous, active low) clears all assemblies and the valid bits at once,
// so there is no clearing pass. Registers come up as address 0, parsing on, link
// down. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.

module can_message_reassembler
    import cmr_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF,
    parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // frame input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ID_W-1:0]       i_frame_ident,
    input  logic [CNT_W-1:0]      i_byte_count,
    input  logic [DATA_W-1:0]     i_frame_bytes,
    // piece output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [NODE_W-1:0]     o_source_node,
    output logic [NODE_W-1:0]     o_dest_node,
    output logic [PRI_W-1:0]      o_msg_priority,
    output logic [CNT_W-1:0]      o_piece_len,
    output logic [DATA_W-1:0]     o_piece_bytes,
    output logic                  o_last_piece
);

    localparam int DEPTH  = NUM_SOURCES * MAX_CHUNKS;
    localparam int RAM_AW = $clog2(DEPTH);
    localparam int SRC_W  = $clog2(NUM_SOURCES);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SLOT  = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;

    // Control state
    logic [2:0]             r_state, n_state;
    logic [NODE_W-1:0]      r_own, n_own;
    logic                   r_parse, n_parse;
    logic                   r_link, n_link;
    logic [NUM_SOURCES-1:0] r_active, n_active;
    logic [TALLY_W-1:0]     r_tally [NUM_SOURCES];
    logic [TALLY_W-1:0]     n_tally [NUM_SOURCES];
    logic [DEPTH-1:0]       r_slot_vld, n_slot_vld;
    logic                   r_o_valid, n_o_valid;

    // Item and piece payload
    logic [ID_W-1:0]        r_ident, n_ident;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [DATA_W-1:0]      r_data, n_data;
    logic [TALLY_W-1:0]     r_k, n_k;
    logic                   r_lone, n_lone;
    logic                   r_rd_vld, n_rd_vld;
    logic [NODE_W-1:0]      r_p_src, n_p_src;
    logic [NODE_W-1:0]      r_p_dst, n_p_dst;
    logic [PRI_W-1:0]       r_p_pri, n_p_pri;
    logic [CNT_W-1:0]       r_p_len, n_p_len;
    logic [DATA_W-1:0]      r_p_bytes, n_p_bytes;
    logic                   r_p_last, n_p_last;

    // Decode of the held frame
    logic [PRI_W-1:0]   w_pri;
    logic               w_more;
    logic [NODE_W-1:0]  w_dst;
    logic [NODE_W-1:0]  w_src;
    logic [SRC_W-1:0]   w_sidx;
    logic               w_src_ok;
    logic               w_active;
    logic [TALLY_W-1:0] w_tally;
    logic               w_dst_ok;
    logic               w_cfg_on;
    logic [7:0]         w_lead;
    logic [7:0]         w_lead_off;
    logic               w_idx_ok;
    logic               w_store;
    logic [CNT_W-1:0]   w_n_sat;
    logic               w_out_free;

    // Shared address adder: slot base plus slot index or readout counter
    logic [RAM_AW-1:0]  w_base;
    logic [RAM_AW-1:0]  w_addr;
    logic               w_ram_we;
    logic [SLOT_W-1:0]  w_ram_wdata;
    logic [SLOT_W-1:0]  w_ram_rdata;

    assign w_pri      = r_ident[10:9];
    assign w_more     = r_ident[8];
    assign w_dst      = r_ident[7:4];
    assign w_src      = r_ident[3:0];
    assign w_sidx     = w_src[SRC_W-1:0];
    assign w_src_ok   = {1'b0, w_src} < 5'(NUM_SOURCES);
    assign w_active   = w_src_ok && r_active[w_sidx];
    assign w_tally    = r_tally[w_sidx];
    assign w_dst_ok   = (w_dst == r_own) || (w_dst == BCAST_ADDR);
    assign w_cfg_on   = r_link && r_parse;
    assign w_lead     = r_data[7:0];
    assign w_lead_off = w_lead - DIGIT_ZERO;
    assign w_idx_ok   = (w_lead >= DIGIT_ZERO) && (w_lead_off < 8'(MAX_CHUNKS));
    assign w_store    = w_cfg_on && w_dst_ok && w_more && w_src_ok && (r_n != '0)
                        && w_idx_ok && (w_tally < TALLY_W'(MAX_CHUNKS));
    assign w_n_sat    = (i_byte_count > MAX_BYTES) ? MAX_BYTES : i_byte_count;
    assign w_out_free = !r_o_valid || !i_out_stall;

    assign w_base = RAM_AW'(w_sidx) * RAM_AW'(MAX_CHUNKS);
    assign w_addr = w_base + ((r_state == S_CHECK) ? RAM_AW'(w_lead_off[3:0])
                                                   : RAM_AW'(r_k));

    assign w_ram_we    = (r_state == S_CHECK) && w_store;
    assign w_ram_wdata = {SLEN_W'(r_n - 4'd1), r_data[63:8]};

    cmr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer and next-state logic
    always_comb begin
        n_state    = r_state;
        n_own      = r_own;
        n_parse    = r_parse;
        n_link     = r_link;
        n_active   = r_active;
        n_tally    = r_tally;
        n_slot_vld = r_slot_vld;
        n_o_valid  = r_o_valid && i_out_stall;
        n_ident    = r_ident;
        n_n        = r_n;
        n_data     = r_data;
        n_k        = r_k;
        n_lone     = r_lone;
        n_rd_vld   = r_rd_vld;
        n_p_src    = r_p_src;
        n_p_dst    = r_p_dst;
        n_p_pri    = r_p_pri;
        n_p_len    = r_p_len;
        n_p_bytes  = r_p_bytes;
        n_p_last   = r_p_last;

        // register writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OWN_ADDR: n_own   = i_cfg_data[NODE_W-1:0];
                REG_PARSE_EN: n_parse = i_cfg_data[0];
                REG_LINK_RDY: n_link  = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ident = i_frame_ident;
                    n_n     = w_n_sat;
                    n_data  = keep_bytes(i_frame_bytes, w_n_sat);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_cfg_on || !w_dst_ok) begin
                    n_state = S_IDLE;
                end else if (!w_active && !w_more) begin
                    // lone frame: emitted whole
                    n_lone  = 1'b1;
                    n_state = S_LAST;
                end else if (w_more || !w_src_ok) begin
                    // continuation: store chunk if index and tally allow
                    if (w_store) begin
                        n_tally[w_sidx]    = w_tally + 4'd1;
                        n_active[w_sidx]   = 1'b1;
                        n_slot_vld[w_addr] = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    // final frame: read out stored slots
                    n_lone  = 1'b0;
                    n_k     = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_rd_vld = r_slot_vld[w_addr];
                n_state  = S_SLOT;
            end
            S_SLOT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_p_src   = w_src;
                    n_p_dst   = w_dst;
                    n_p_pri   = w_pri;
                    n_p_last  = 1'b0;
                    n_p_len   = r_rd_vld ? CNT_W'(w_ram_rdata[SLOT_W-1:SBYTES_W]) : '0;
                    n_p_bytes = r_rd_vld ? DATA_W'(w_ram_rdata[SBYTES_W-1:0]) : '0;
                    n_k       = r_k + 4'd1;
                    n_state   = ((r_k + 4'd1) < w_tally) ? S_READ : S_LAST;
                end
            end
            S_LAST: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_p_src   = w_src;
                    n_p_dst   = w_dst;
                    n_p_pri   = w_pri;
                    n_p_last  = 1'b1;
                    if (r_lone) begin
                        n_p_len   = r_n;
                        n_p_bytes = r_data;
                    end else begin
                        n_p_len   = (r_n == '0) ? '0 : r_n - 4'd1;
                        n_p_bytes = {8'h00, r_data[63:8]};
                        for (int j = 0; j < MAX_CHUNKS; j++) begin
                            n_slot_vld[w_base + RAM_AW'(j)] = 1'b0;
                        end
                        n_tally[w_sidx]  = '0;
                        n_active[w_sidx] = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_own      <= '0;
            r_parse    <= 1'b1;
            r_link     <= 1'b0;
            r_active   <= '0;
            r_tally    <= '{default: '0};
            r_slot_vld <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_own      <= n_own;
            r_parse    <= n_parse;
            r_link     <= n_link;
            r_active   <= n_active;
            r_tally    <= n_tally;
            r_slot_vld <= n_slot_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ident   <= n_ident;
        r_n       <= n_n;
        r_data    <= n_data;
        r_k       <= n_k;
        r_lone    <= n_lone;
        r_rd_vld  <= n_rd_vld;
        r_p_src   <= n_p_src;
        r_p_dst   <= n_p_dst;
        r_p_pri   <= n_p_pri;
        r_p_len   <= n_p_len;
        r_p_bytes <= n_p_bytes;
        r_p_last  <= n_p_last;
    end

    // Every piece field comes from the output register, so a waiting piece holds
    // while the next frame is taken in
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_source_node  = r_p_src;
    assign o_dest_node    = r_p_dst;
    assign o_msg_priority = r_p_pri;
    assign o_piece_len    = r_p_len;
    assign o_piece_bytes  = r_p_bytes;
    assign o_last_piece   = r_p_last;

endmodule

/* src/cmr_ram.sv */
`timescale 1ns / 1ps

module cmr_ram
    import cmr_pkg::*;
#(
    parameter int WIDTH = SLOT_W,
    parameter int DEPTH = NUM_SOURCES_DEF * MAX_CHUNKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cmr_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmr_checker
    import cmr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [CNT_W-1:0]      o_piece_len,
    input logic [DATA_W-1:0]     o_piece_bytes,
    input logic                  o_last_piece
);

    // A piece never exceeds one frame's payload
    `ASSERT_IMP(a_len_max, i_clk, i_rst_n, o_out_valid, o_piece_len <= 4'd8)

    // Stored slots lose the index byte, so only the last piece can be full
    `ASSERT_IMP(a_slot_len, i_clk, i_rst_n, o_out_valid && !o_last_piece, o_piece_len <= 4'd7)

    // Bytes above the piece length are zero (top byte check)
    `ASSERT_IMP(a_top_zero, i_clk, i_rst_n, o_out_valid && o_piece_len <= 4'd7, o_piece_bytes[63:56] == 8'h00)

    // The block is busy right after it takes a frame
    `ASSERT_NXT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A stalled piece holds
    `ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_piece_bytes) && $stable(o_piece_len) && $stable(o_last_piece))

endmodule

bind can_message_reassembler cmr_checker u_cmr_checker (.*);

/* tb/can_message_reassembler_tb.sv */
`timescale 1ns / 1ps

module can_message_reassembler_tb;
    import cmr_pkg::*;

    localparam int NSRC        = NUM_SOURCES_DEF;
    localparam int NSLOT       = MAX_CHUNKS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 30;

    typedef struct {
        logic [ID_W-1:0]   ident;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] bytes;
    } frame_t;

    typedef struct {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [PRI_W-1:0]  pri;
        logic [CNT_W-1:0]  len;
        logic [DATA_W-1:0] bytes;
        logic              last;
    } piece_t;

    // DUT inputs start at known values
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic [ID_W-1:0]       i_frame_ident = '0;
    logic [CNT_W-1:0]      i_byte_count = '0;
    logic [DATA_W-1:0]     i_frame_bytes = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [NODE_W-1:0]     o_source_node;
    logic [NODE_W-1:0]     o_dest_node;
    logic [PRI_W-1:0]      o_msg_priority;
    logic [CNT_W-1:0]      o_piece_len;
    logic [DATA_W-1:0]     o_piece_bytes;
    logic                  o_last_piece;

    can_message_reassembler dut (.*);

    // Frames waiting to be driven, pieces waiting to come out
    frame_t frames_queued[$];
    piece_t pieces_due[$];
    frame_t cur_frame;

    // Predictor copy of the registers and the per-source assembly state
    logic [NODE_W-1:0] node_addr = '0;
    logic              parse_on = 1'b1;
    logic              link_up = 1'b0;
    logic              assembling[NSRC];
    int                chunk_count[NSRC];
    logic [55:0]       chunk_data[NSRC][NSLOT];
    logic [2:0]        chunk_len[NSRC][NSLOT];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  tx_eager = 1'b0;
    bit  rx_eager = 1'b0;
    bit  receiver_hold_req = 1'b0;
    bit  hold_done = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] low_bytes(logic [63:0] v, int n);
        return (n >= 8) ? v : v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic void emit_piece(logic [3:0] src, logic [3:0] dst, logic [1:0] pri,
                                       int len, logic [63:0] bytes, logic last);
        piece_t p;
        p.src   = src;
        p.dst   = dst;
        p.pri   = pri;
        p.len   = CNT_W'(len);
        p.bytes = low_bytes(bytes, len);
        p.last  = last;
        pieces_due.push_back(p);
    endfunction

    // Work out the pieces one accepted frame produces
    function automatic void reassemble_frame(frame_t f);
        logic [1:0]  pri;
        logic        more;
        logic [3:0]  dst;
        logic [3:0]  src;
        logic [63:0] data;
        int          n;
        int          slot;
        if (!link_up || !parse_on) return;
        pri  = f.ident[10:9];
        more = f.ident[8];
        dst  = f.ident[7:4];
        src  = f.ident[3:0];
        n    = (f.count > MAX_BYTES) ? 8 : int'(f.count);
        data = low_bytes(f.bytes, n);
        if (dst != node_addr && dst != BCAST_ADDR) return;
        // no assembly open: a final frame goes out whole
        if (!assembling[src] && !more) begin
            emit_piece(src, dst, pri, n, data, 1'b1);
            return;
        end
        if (more) begin
            if (n == 0) return;
            slot = int'(data[7:0]) - int'(DIGIT_ZERO);
            if (slot < 0 || slot >= NSLOT) return;
            if (chunk_count[src] >= NSLOT) return;
            chunk_data[src][slot] = data[63:8];
            chunk_len[src][slot]  = 3'(n - 1);
            chunk_count[src]++;
            assembling[src] = 1'b1;
            return;
        end
        // readout of stored slots, then the frame's own bytes after the index
        for (int k = 0; k < chunk_count[src]; k++) begin
            emit_piece(src, dst, pri, int'(chunk_len[src][k]), {8'h00, chunk_data[src][k]},
                       1'b0);
        end
        emit_piece(src, dst, pri, (n > 0) ? n - 1 : 0, data >> 8, 1'b1);
        for (int k = 0; k < NSLOT; k++) chunk_len[src][k] = '0;
        chunk_count[src] = 0;
        assembling[src]  = 1'b0;
    endfunction

    function automatic int draw_wait(bit eager);
        return eager ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random data with the slot index in byte 0
    function automatic logic [63:0] chunk_bytes(logic [7:0] lead);
        logic [63:0] v;
        v = rand64();
        v[7:0] = lead;
        return v;
    endfunction

    function automatic logic [3:0] draw_count(int lo);
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
        return 4'($urandom_range(lo, 8));
    endfunction

    // Mostly our node or broadcast, sometimes anything
    function automatic logic [3:0] pick_dest();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return node_addr;
        if (r < 8) return BCAST_ADDR;
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic queue_frame(logic [1:0] pri, logic more, logic [3:0] dst, logic [3:0] src,
                               logic [3:0] cnt, logic [63:0] bytes);
        frame_t f;
        f.ident = {pri, more, dst, src};
        f.count = cnt;
        f.bytes = bytes;
        frames_queued.push_back(f);
    endtask

    // Well-formed assemblies with random content, plus lone frames and noise
    task automatic queue_random_traffic(int count);
        int         added;
        int         kind;
        int         chunks;
        logic [3:0] src;
        logic [7:0] lead;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(0, 9);
            src  = 4'($urandom_range(0, 15));
            if (kind < 6) begin
                chunks = ($urandom_range(0, 4) == 0) ? $urandom_range(NSLOT, NSLOT + 1)
                                                     : $urandom_range(0, 6);
                repeat (chunks) begin
                    if ($urandom_range(0, 9) == 0) lead = 8'($urandom);
                    else lead = DIGIT_ZERO + 8'($urandom_range(0, NSLOT - 1));
                    queue_frame(2'($urandom), 1'b1, pick_dest(), src, draw_count(1),
                                chunk_bytes(lead));
                end
                queue_frame(2'($urandom), 1'b0, pick_dest(), src, draw_count(0), rand64());
                added += chunks + 1;
            end else if (kind < 8) begin
                queue_frame(2'($urandom), 1'b0, pick_dest(), src, draw_count(0), rand64());
                added++;
            end else begin
                queue_frame(2'($urandom), 1'($urandom), 4'($urandom), src, 4'($urandom),
                            rand64());
                added++;
            end
        end
    endtask

    // Block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do @(negedge i_clk);
        while (frames_queued.size() != 0 || i_in_valid || pieces_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_OWN_ADDR: node_addr = val[NODE_W-1:0];
            REG_PARSE_EN: parse_on = val[0];
            REG_LINK_RDY: link_up = val[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Frame driver: one item per handshake, random gap after each
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                reassemble_frame(cur_frame);
                if ($urandom_range(0, 15) == 0) tx_eager = !tx_eager;
                gap_left = draw_wait(tx_eager);
                if (gap_left == 0 && frames_queued.size() > 0) begin
                    cur_frame = frames_queued.pop_front();
                    i_frame_ident <= cur_frame.ident;
                    i_byte_count  <= cur_frame.count;
                    i_frame_bytes <= cur_frame.bytes;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (frames_queued.size() > 0) begin
                    cur_frame = frames_queued.pop_front();
                    i_frame_ident <= cur_frame.ident;
                    i_byte_count  <= cur_frame.count;
                    i_frame_bytes <= cur_frame.bytes;
                    i_in_valid    <= 1'b1;
                end
            end
        end
    end

    // Piece monitor: checks each item, then stalls at random
    always @(posedge i_clk) begin
        piece_t want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pieces_due.size() == 0) begin
                    $error("piece from source %0d with nothing expected", o_source_node);
                    fail_count++;
                end else begin
                    want = pieces_due.pop_front();
                    check_field("source_node", 64'(want.src), 64'(o_source_node));
                    check_field("dest_node", 64'(want.dst), 64'(o_dest_node));
                    check_field("msg_priority", 64'(want.pri), 64'(o_msg_priority));
                    check_field("piece_len", 64'(want.len), 64'(o_piece_len));
                    check_field("piece_bytes", want.bytes, o_piece_bytes);
                    check_field("last_piece", 64'(want.last), 64'(o_last_piece));
                end
            end
            if (receiver_hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
                stall_left = draw_wait(rx_eager);
                i_out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < NSRC; s++) begin
            assembling[s]  = 1'b0;
            chunk_count[s] = 0;
            for (int k = 0; k < NSLOT; k++) begin
                chunk_data[s][k] = '0;
                chunk_len[s][k]  = '0;
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // link still down after reset: frames are ignored
        queue_frame(2'd0, 1'b0, 4'd0, 4'd1, 4'd8, rand64());
        queue_frame(2'd1, 1'b1, 4'd0, 4'd2, 4'd3, chunk_bytes(DIGIT_ZERO));
        queue_frame(2'd2, 1'b0, BCAST_ADDR, 4'd2, 4'd4, rand64());
        wait_drained();

        write_reg(REG_LINK_RDY, 4'd1);
        write_reg(REG_OWN_ADDR, 4'd5);

        // write every slot of a spread of sources once, in scrambled order, then read out
        for (int s = 0; s < NSRC; s += 5) begin
            for (int i = 0; i < NSLOT; i++) begin
                queue_frame(2'($urandom), 1'b1, node_addr, 4'(s), 4'($urandom_range(1, 8)),
                            chunk_bytes(DIGIT_ZERO + 8'((i * 3 + s) % NSLOT)));
            end
            queue_frame(2'($urandom), 1'b0, BCAST_ADDR, 4'(s), draw_count(0), rand64());
        end

        // lone frames: empty, full, oversize count to broadcast from the top source
        queue_frame(2'd0, 1'b0, node_addr, 4'd1, 4'd0, '1);
        queue_frame(2'd3, 1'b0, node_addr, 4'd2, 4'd8, '1);
        queue_frame(2'd1, 1'b0, BCAST_ADDR, 4'd15, 4'd15, rand64());
        // addressed elsewhere: dropped
        queue_frame(2'd2, 1'b0, 4'd4, 4'd1, 4'd8, rand64());
        queue_frame(2'd0, 1'b1, 4'd0, 4'd3, 4'd4, chunk_bytes(DIGIT_ZERO));
        // source 3: slots 0 and 2, digits out of range, empty chunk, short final
        queue_frame(2'd1, 1'b1, node_addr, 4'd3, 4'd8, chunk_bytes(DIGIT_ZERO));
        queue_frame(2'd1, 1'b1, node_addr, 4'd3, 4'd1, chunk_bytes(DIGIT_ZERO + 8'd2));
        queue_frame(2'd1, 1'b1, node_addr, 4'd3, 4'd3, chunk_bytes(DIGIT_ZERO - 8'd1));
        queue_frame(2'd1, 1'b1, node_addr, 4'd3, 4'd3, chunk_bytes(DIGIT_ZERO + 8'(NSLOT)));
        queue_frame(2'd1, 1'b1, node_addr, 4'd3, 4'd0, chunk_bytes(DIGIT_ZERO + 8'd1));
        queue_frame(2'd1, 1'b0, node_addr, 4'd3, 4'd1, rand64());
        // source 7: slot 9 twice, then up to the chunk limit; the last one is dropped
        queue_frame(2'd0, 1'b1, node_addr, 4'd7, 4'd5, chunk_bytes(DIGIT_ZERO + 8'd9));
        queue_frame(2'd0, 1'b1, node_addr, 4'd7, 4'd8, chunk_bytes(DIGIT_ZERO + 8'd9));
        for (int i = 0; i < NSLOT - 1; i++) begin
            queue_frame(2'd0, 1'b1, node_addr, 4'd7, 4'(i % 8 + 1),
                        chunk_bytes(DIGIT_ZERO + 8'(i)));
        end
        queue_frame(2'd2, 1'b0, BCAST_ADDR, 4'd7, 4'd8, rand64());
        // source 3 idle again: goes out whole, count saturates
        queue_frame(2'd3, 1'b0, node_addr, 4'd3, 4'd9, rand64());
        wait_drained();

        // random traffic; the receiver holds off once while frames keep coming
        queue_random_traffic(60);
        do @(negedge i_clk);
        while (frames_queued.size() > 40);
        receiver_hold_req = 1'b1;
        wait_drained();
        queue_random_traffic(25);
        wait_drained();

        // own address equal to broadcast
        write_reg(REG_OWN_ADDR, 4'd15);
        queue_random_traffic(25);
        wait_drained();

        // parsing off: everything ignored
        write_reg(REG_PARSE_EN, 4'd0);
        queue_random_traffic(8);
        wait_drained();

        write_reg(REG_PARSE_EN, 4'd1);
        write_reg(REG_OWN_ADDR, 4'd0);
        queue_random_traffic(25);
        wait_drained();

        // link dropped again
        write_reg(REG_LINK_RDY, 4'd0);
        queue_random_traffic(5);
        wait_drained();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
